FILE: sv/otrb_pkg.sv
// ----------------------------------------------------------------------------
// otrb_pkg: shared types and constants of the overwriting trace ring buffer
// Operation codes, status codes, ring geometry and pointer helper.
// ----------------------------------------------------------------------------
`default_nettype none

package otrb_pkg;

  // Ring geometry: DEPTH slots, at most DEPTH-1 records held
  localparam int unsigned DEPTH   = 40;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STK_W   = 16;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOMARK   = 2'd2,
    ST_LOGOFF   = 2'd3
  } status_e;

  // Advance a ring pointer with wrap at the last slot
  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/otrb_ram.sv
// ----------------------------------------------------------------------------
// otrb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module otrb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/overwriting_trace_ring_buffer_unit.sv
// A result is registered and presented the cycle after it is accepted.
// Throughput: one transaction per cycle while no stall holds the result;
//   records use the ring RAM's one write port and reads its one read port.
// Reset (rst_ni low, asynchronous): pointers, count, logging flag, marker and
//   stack peak clear; ring contents are not cleared and hold stale data.
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer_unit: overwriting trace ring buffer
// Stores (address, value) trace records in a ring, overwriting the oldest
// when full, pops the oldest on read and tracks the peak stack usage.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_trace_ring_buffer_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               func_i,
  input  wire logic [otrb_pkg::ADDR_W-1:0] entry_addr_i,
  input  wire logic [otrb_pkg::VAL_W-1:0]  entry_value_i,
  input  wire logic [otrb_pkg::STK_W-1:0]  stack_used_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic [otrb_pkg::ADDR_W-1:0]   read_addr_o,
  output logic [otrb_pkg::VAL_W-1:0]    read_value_o,
  output logic [otrb_pkg::CNT_W-1:0]    entry_count_o,
  output logic [otrb_pkg::STK_W-1:0]    max_stack_o,
  output logic                          logging_on_o
);

  import otrb_pkg::*;

  // --------------------------------------------------------------------------
  // Ring state
  // --------------------------------------------------------------------------
  ptr_t              read_ptr_q,   read_ptr_d;
  ptr_t              write_ptr_q,  write_ptr_d;
  cnt_t              held_count_q, held_count_d;
  logic              running_q,    running_d;
  logic              marker_q,     marker_d;
  logic [STK_W-1:0]  peak_q,       peak_d;

  // Result register; popped data lives in the RAM read register
  logic              out_valid_q;
  status_e           status_q,     status_d;
  logic              rd_sel_q,     rd_sel_d;

  logic              in_accept;
  logic              ram_we;
  logic              ram_re;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  func_e             func;

  // The output register is free when empty or being taken this cycle
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign func       = func_e'(func_i);
  assign ram_wdata  = {entry_value_i, entry_addr_i};

  // --------------------------------------------------------------------------
  // Per-transaction update: all decisions come from the current state
  // --------------------------------------------------------------------------
  always_comb begin
    read_ptr_d   = read_ptr_q;
    write_ptr_d  = write_ptr_q;
    held_count_d = held_count_q;
    running_d    = running_q;
    marker_d     = marker_q;
    peak_d       = peak_q;
    status_d     = ST_OK;
    rd_sel_d     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (func)
      FUNC_RECORD: begin
        if (stack_used_i > peak_q) begin
          peak_d = stack_used_i;
        end
        if (!running_q) begin
          status_d = ST_LOGOFF;
        end else begin
          // full ring: drop the oldest record before appending
          if (next_slot(write_ptr_q) == read_ptr_q) begin
            read_ptr_d   = next_slot(read_ptr_q);
            held_count_d = held_count_q;
          end else begin
            held_count_d = cnt_t'(held_count_q + 1'b1);
          end
          ram_we      = 1'b1;
          write_ptr_d = next_slot(write_ptr_q);
          marker_d    = 1'b1;
        end
      end
      FUNC_READ: begin
        if (write_ptr_q == read_ptr_q) begin
          status_d = ST_EMPTY;
        end else if (!marker_q) begin
          status_d = ST_NOMARK;
        end else begin
          ram_re     = 1'b1;
          rd_sel_d   = 1'b1;
          read_ptr_d = next_slot(read_ptr_q);
          if (held_count_q != '0) begin
            held_count_d = cnt_t'(held_count_q - 1'b1);
          end
        end
      end
      FUNC_START: begin
        read_ptr_d   = '0;
        write_ptr_d  = '0;
        held_count_d = '0;
        running_d    = 1'b1;
      end
      default: begin
        // unused selector: state untouched, status ok
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_ptr_q   <= '0;
      write_ptr_q  <= '0;
      held_count_q <= '0;
      running_q    <= 1'b0;
      marker_q     <= 1'b0;
      peak_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        read_ptr_q   <= read_ptr_d;
        write_ptr_q  <= write_ptr_d;
        held_count_q <= held_count_d;
        running_q    <= running_d;
        marker_q     <= marker_d;
        peak_q       <= peak_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  // --------------------------------------------------------------------------
  // Ring storage; read data register only loads on a successful pop
  // --------------------------------------------------------------------------
  otrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept & ram_we),
    .waddr_i (write_ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_accept & ram_re),
    .raddr_i (read_ptr_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Outputs: count, peak and logging flag are the post-transaction state
  // --------------------------------------------------------------------------
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_addr_o   = rd_sel_q ? ram_rdata[ADDR_W-1:0] : '0;
  assign read_value_o  = rd_sel_q ? ram_rdata[ENTRY_W-1:ADDR_W] : '0;
  assign entry_count_o = held_count_q;
  assign max_stack_o   = peak_q;
  assign logging_on_o  = running_q;

`ifndef ASSERT_OFF
  // ring never holds more than DEPTH-1 records
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= cnt_t'(DEPTH - 1))
    else $error("held count beyond ring capacity");

  // pointers stay inside the ring
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_ptr_q < ptr_t'(DEPTH)) && (write_ptr_q < ptr_t'(DEPTH)))
    else $error("ring pointer out of range");

  // popped data is only shown with an ok status
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rd_sel_q |-> status_q == ST_OK)
    else $error("read data shown with error status");

  // an accepted read of an empty ring leaves the pointers unchanged
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (func == FUNC_READ) && (write_ptr_q == read_ptr_q)
    |=> $stable(read_ptr_q) && $stable(write_ptr_q))
    else $error("empty read moved a pointer");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for overwriting_trace_ring_buffer_unit
// Drives record, read, start and unused operations through the valid/stall
// input channel, mirrors the ring in a local model and compares every result
// transaction field by field, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;

  import otrb_pkg::*;

  // One result transaction as the block reports it
  typedef struct {
    status_e            status;
    logic [ADDR_W-1:0]  addr;
    logic [VAL_W-1:0]   value;
    cnt_t               count;
    logic [STK_W-1:0]   peak;
    logic               logging;
  } trace_report_t;

  // Clock and reset; every input known from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Input channel
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [1:0]          func_i        = 2'b00;
  logic [ADDR_W-1:0]   entry_addr_i  = '0;
  logic [VAL_W-1:0]    entry_value_i = '0;
  logic [STK_W-1:0]    stack_used_i  = '0;

  // Result channel
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   read_addr_o;
  logic [VAL_W-1:0]    read_value_o;
  logic [CNT_W-1:0]    entry_count_o;
  logic [STK_W-1:0]    max_stack_o;
  logic                logging_on_o;

  overwriting_trace_ring_buffer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_addr_i  (entry_addr_i),
    .entry_value_i (entry_value_i),
    .stack_used_i  (stack_used_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_addr_o   (read_addr_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .max_stack_o   (max_stack_o),
    .logging_on_o  (logging_on_o)
  );

  // Idle mix, in percent per cycle, changed between test phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Upper bound for random stack usage; it creeps up so the peak keeps moving
  int unsigned stk_ceiling    = 16;

  int unsigned err_cnt        = 0;

  // Local copy of the ring state
  entry_t          ring_slots [DEPTH];
  ptr_t            rd_slot    = '0;
  ptr_t            wr_slot    = '0;
  cnt_t            held       = '0;
  logic            logging    = 1'b0;
  logic            marker     = 1'b0;
  logic [STK_W-1:0] peak      = '0;

  // Reports owed by the block, oldest first
  trace_report_t   trace_reports_due [$];
  trace_report_t   seen_due;

  // Ring pointer step, wrapping after the last slot
  function automatic ptr_t slot_after(input ptr_t p);
    int unsigned n;
    n = (int'(p) + 1) % DEPTH;
    return ptr_t'(n);
  endfunction

  // Apply one accepted operation to the local ring and queue the report it owes
  task automatic ring_apply(input func_e op, input logic [ADDR_W-1:0] addr,
                            input logic [VAL_W-1:0] value,
                            input logic [STK_W-1:0] stk);
    trace_report_t rep;
    entry_t        e;
    rep.status = ST_OK;
    rep.addr   = '0;
    rep.value  = '0;
    case (op)
      FUNC_RECORD: begin
        // peak tracks stack usage whether or not logging is on
        if (stk > peak) peak = stk;
        if (!logging) begin
          rep.status = ST_LOGOFF;
        end else begin
          // ring full: drop the oldest record first
          if (slot_after(wr_slot) == rd_slot) begin
            rd_slot = slot_after(rd_slot);
            if (held != '0) held = held - 1'b1;
          end
          ring_slots[wr_slot] = {value, addr};
          wr_slot = slot_after(wr_slot);
          held    = held + 1'b1;
          marker  = 1'b1;
        end
      end
      FUNC_READ: begin
        // empty beats missing marker
        if (wr_slot == rd_slot) begin
          rep.status = ST_EMPTY;
        end else if (!marker) begin
          rep.status = ST_NOMARK;
        end else begin
          e         = ring_slots[rd_slot];
          rep.addr  = e[ADDR_W-1:0];
          rep.value = e[ENTRY_W-1:ADDR_W];
          rd_slot   = slot_after(rd_slot);
          if (held != '0) held = held - 1'b1;
        end
      end
      FUNC_START: begin
        // marker and peak survive a start
        rd_slot = '0;
        wr_slot = '0;
        held    = '0;
        logging = 1'b1;
      end
      default: ; // unused selector leaves everything alone
    endcase
    rep.count   = held;
    rep.peak    = peak;
    rep.logging = logging;
    trace_reports_due.push_back(rep);
  endtask

  // Send one transaction; valid is left high so back-to-back items need no
  // drop. An idle gap lowers it once, then raises it again a later cycle.
  task automatic issue_op(input func_e op, input logic [ADDR_W-1:0] addr,
                          input logic [VAL_W-1:0] value,
                          input logic [STK_W-1:0] stk);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    entry_addr_i  <= addr;
    entry_value_i <= value;
    stack_used_i  <= stk;
    // accepted at the first edge that sees valid high and stall low
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ring_apply(op, addr, value, stk);
  endtask

  // Words biased towards the edges and the magic pattern
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1234_5678;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STK_W-1:0] pick_stack();
    return STK_W'($urandom_range(stk_ceiling));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Result side: compare each accepted report with the oldest owed one,
  // then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (trace_reports_due.size() == 0) begin
        $error("unexpected result transaction, status 0x%0h", status_o);
        err_cnt++;
      end else begin
        seen_due = trace_reports_due.pop_front();
        check_field("status",      32'(seen_due.status),  32'(status_o));
        check_field("read_addr",   seen_due.addr,         read_addr_o);
        check_field("read_value",  seen_due.value,        read_value_o);
        check_field("entry_count", 32'(seen_due.count),   32'(entry_count_o));
        check_field("max_stack",   32'(seen_due.peak),    32'(max_stack_o));
        check_field("logging_on",  32'(seen_due.logging), 32'(logging_on_o));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- tests

  // Freshly reset: nothing held, logging off, unused selector is harmless
  task automatic test_idle_after_reset();
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // Records before a start are refused but still raise the stack peak
  task automatic test_logging_off();
    issue_op(FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3);
    issue_op(FUNC_RECORD, 32'h1234_5678, 32'h0, 16'd1);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
  endtask

  // Start, then store and pop records with edge values, in order
  task automatic test_record_read();
    issue_op(FUNC_START, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_RECORD, 32'h0000_0000, 32'h0000_0000, 16'd0);
    issue_op(FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd7);
    issue_op(FUNC_RECORD, 32'h1234_5678, 32'hA5A5_5A5A, 16'd2);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_NOP, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
  endtask

  // A start while records are held empties the ring but keeps the peak
  task automatic test_start_clears();
    issue_op(FUNC_RECORD, 32'hDEAD_0001, 32'h0000_0001, 16'd9);
    issue_op(FUNC_RECORD, 32'hDEAD_0002, 32'h0000_0002, 16'd4);
    issue_op(FUNC_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
    issue_op(FUNC_RECORD, 32'hCAFE_0003, 32'h8000_0000, 16'd1);
    issue_op(FUNC_READ, 32'h0, 32'h0, 16'h0);
  endtask

  // Overfill the ring so the oldest records get overwritten, then drain it
  task automatic test_ring_wrap();
    issue_op(FUNC_START, pick_word(), pick_word(), 16'($urandom_range(16'hFFFF)));
    repeat (DEPTH + 7) issue_op(FUNC_RECORD, pick_word(), pick_word(), pick_stack());
    repeat (DEPTH + 2) issue_op(FUNC_READ, pick_word(), pick_word(),
                                16'($urandom_range(16'hFFFF)));
  endtask

  // Random segments, each leaning towards records, reads or a balance
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned done;
    int unsigned seg_left;
    int unsigned rec_pct;
    int unsigned r;
    func_e       op;
    logic [STK_W-1:0] stk;
    done     = 0;
    seg_left = 0;
    rec_pct  = 50;
    while (done < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(80, 30);
        case ($urandom_range(2))
          0:       rec_pct = 92;
          1:       rec_pct = 55;
          default: rec_pct = 25;
        endcase
      end
      r = $urandom_range(99);
      if (r < 1)                 op = FUNC_START;
      else if (r < 4)            op = FUNC_NOP;
      else if (r < 4 + rec_pct)  op = FUNC_RECORD;
      else                       op = FUNC_READ;
      // only records sample the stack; other ops carry full-range noise
      stk = (op == FUNC_RECORD) ? pick_stack() : 16'($urandom_range(16'hFFFF));
      issue_op(op, pick_word(), pick_word(), stk);
      if (stk_ceiling < 16'hFFFF) stk_ceiling = stk_ceiling + 48;
      if (stk_ceiling > 16'hFFFF) stk_ceiling = 16'hFFFF;
      seg_left--;
      done++;
    end
  endtask

  // Top of the stack range; after this the peak stays pinned
  task automatic test_peak_saturate();
    issue_op(FUNC_RECORD, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(FUNC_RECORD, 32'h0, 32'h0, 16'h0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned guard;
    guard = 0;

    // asynchronous reset held from time zero, released on an edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_idle_after_reset();
    test_logging_off();
    test_record_read();
    test_start_clears();

    // random part over the four idle mixes
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    test_ring_wrap();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(320);
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    test_random_mix(320);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    test_random_mix(320);
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    test_random_mix(300);

    send_idle_pct  = 0;
    test_peak_saturate();
    in_valid_i <= 1'b0;

    // drain: wait for every owed report, then keep watching for stray results
    while (trace_reports_due.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);

    if (trace_reports_due.size() != 0) begin
      $error("%0d result transactions never arrived", trace_reports_due.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("overwriting_trace_ring_buffer_unit regression: pass");
    end else begin
      $display("overwriting_trace_ring_buffer_unit regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("overwriting_trace_ring_buffer_unit regression: fail");
    $finish;
  end

endmodule
